FILE: src/assert_macros.svh
// Assertion macros shared by the I2C master sequencer modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: src/i2cms_pkg.sv
// Types and constants of the I2C master bit sequencer.
// No dependencies; used by all sequencer modules.
package i2cms_pkg;

    localparam int BITS_PER_BYTE = 8;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // phase within one data bit: set SDA, SCL high, SCL low
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    localparam logic [4:0] DATA_SEGS     = 5'(BITS_PER_BYTE * 3);
    localparam logic [4:0] SEG_ACK       = DATA_SEGS;
    localparam logic [4:0] SEG_ACK_HIGH  = 5'(BITS_PER_BYTE * 3 + 1);
    localparam logic [4:0] LEN_START     = 5'd4;
    localparam logic [4:0] LEN_STOP      = 5'd3;
    localparam logic [4:0] LEN_BYTE      = 5'(BITS_PER_BYTE * 3 + 3);

    typedef struct packed {
        op_t                      op;
        logic [BITS_PER_BYTE-1:0] wr_data;
        logic                     send_ack;
        logic                     sda_in;
    } item_t;

    function automatic logic [4:0] seq_len(op_t op);
        case (op)
            OP_START: seq_len = LEN_START;
            OP_STOP:  seq_len = LEN_STOP;
            default:  seq_len = LEN_BYTE;
        endcase
    endfunction

endpackage

FILE: src/i2c_master_bit_sequencer.sv
// I2C master bit sequencer, one 5 us delay segment per tick item.
// A result is offered once its tick item has passed through the queue and then
// the output register.
// Throughput: one item per cycle while m_ready is high; a two-entry queue decouples decode from the
// sequencer, whose one-step update per item sets that rate.
// Reset (aresetn, synchronous, active low): idle, SCL and SDA high, SDA driven,
// queue and output register empty.
module i2c_master_bit_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [7:0]  s_wr_data,
    input  logic        s_send_ack,
    input  logic        s_sda_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic        m_sda_drive,
    output logic        m_ready_res,
    output logic [7:0]  m_read_byte,
    output logic        m_read_done
);

    logic             q_valid;
    logic             q_ready;
    i2cms_pkg::item_t q_item;

    i2cms_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_wr_data  (s_wr_data),
        .s_send_ack (s_send_ack),
        .s_sda_in   (s_sda_in),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_item     (q_item)
    );

    i2cms_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_level (m_scl_level),
        .m_sda_level (m_sda_level),
        .m_sda_drive (m_sda_drive),
        .m_ready_res (m_ready_res),
        .m_read_byte (m_read_byte),
        .m_read_done (m_read_done)
    );

endmodule

FILE: src/i2cms_front.sv
// Front end: accepts tick items, decodes the command code and queues them.
// Depends on i2cms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cms_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_cmd,
    input  logic [7:0]          s_wr_data,
    input  logic                s_send_ack,
    input  logic                s_sda_in,
    output logic                q_valid,
    input  logic                q_ready,
    output i2cms_pkg::item_t    q_item
);

    i2cms_pkg::item_t q_mem_reg [2];
    i2cms_pkg::item_t in_item;
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    // unknown codes act as no command
    always_comb begin
        in_item.wr_data  = s_wr_data;
        in_item.send_ack = s_send_ack;
        in_item.sda_in   = s_sda_in;
        case (s_cmd)
            3'(i2cms_pkg::OP_START): in_item.op = i2cms_pkg::OP_START;
            3'(i2cms_pkg::OP_STOP):  in_item.op = i2cms_pkg::OP_STOP;
            3'(i2cms_pkg::OP_WRITE): in_item.op = i2cms_pkg::OP_WRITE;
            3'(i2cms_pkg::OP_READ):  in_item.op = i2cms_pkg::OP_READ;
            default:                 in_item.op = i2cms_pkg::OP_IDLE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_IMPLIES(a_count_max, aclk, aresetn, 1'b1, count_reg <= 2'd2)
    `ASSERT_IMPLIES(a_ptr_sync, aclk, aresetn,
        (count_reg == 2'd0) || (count_reg == 2'd2), wr_ptr_reg == rd_ptr_reg)

endmodule

FILE: src/i2cms_back.sv
// Back end: runs the bus segment sequencer, one queued tick per step,
// and holds each result in an output register. Depends on i2cms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2cms_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  i2cms_pkg::item_t    q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_scl_level,
    output logic                m_sda_level,
    output logic                m_sda_drive,
    output logic                m_ready_res,
    output logic [7:0]          m_read_byte,
    output logic                m_read_done
);

    i2cms_pkg::op_t op_reg, op_next, cur_op;
    logic [4:0]     seg_reg, seg_next, cur_seg, seg_inc;
    logic [1:0]     phase_reg, phase_next, cur_phase;
    logic [7:0]     shift_reg, shift_next;
    logic           ack_reg, ack_next;
    logic           scl_reg, scl_next;
    logic           sda_reg, sda_next;
    logic           en_reg, en_next;
    logic           idle_res, done;
    logic           fire;

    logic           m_valid_reg;
    logic           ready_res_reg, read_done_reg;
    logic [7:0]     read_byte_reg;

    assign q_ready = !m_valid_reg || m_ready;
    assign fire    = q_valid && q_ready;

    always_comb begin
        op_next    = op_reg;
        seg_next   = seg_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        en_next    = en_reg;
        idle_res   = 1'b0;
        done       = 1'b0;
        cur_op     = op_reg;
        cur_seg    = seg_reg;
        cur_phase  = phase_reg;
        seg_inc    = 5'd0;

        if (op_reg == i2cms_pkg::OP_IDLE) begin
            if (q_item.op != i2cms_pkg::OP_IDLE) begin
                cur_op    = q_item.op;
                cur_seg   = 5'd0;
                cur_phase = i2cms_pkg::PH_DATA;
                if (q_item.op == i2cms_pkg::OP_WRITE) begin
                    shift_next = q_item.wr_data;
                end else if (q_item.op == i2cms_pkg::OP_READ) begin
                    shift_next = 8'd0;
                    ack_next   = q_item.send_ack;
                end
            end else begin
                idle_res = 1'b1;
            end
        end

        case (cur_op)
            i2cms_pkg::OP_START: begin
                case (cur_seg[1:0])
                    2'd0: begin
                        en_next  = 1'b1;
                        sda_next = 1'b1;
                    end
                    2'd1: scl_next = 1'b1;
                    2'd2: sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
            end
            i2cms_pkg::OP_STOP: begin
                case (cur_seg[1:0])
                    2'd0: begin
                        en_next  = 1'b1;
                        sda_next = 1'b0;
                    end
                    2'd1: scl_next = 1'b1;
                    default: sda_next = 1'b1;
                endcase
            end
            i2cms_pkg::OP_WRITE: begin
                if (cur_seg < i2cms_pkg::DATA_SEGS) begin
                    case (cur_phase)
                        i2cms_pkg::PH_DATA: begin
                            sda_next   = shift_next[7];
                            shift_next = {shift_next[6:0], 1'b0};
                        end
                        i2cms_pkg::PH_HIGH: scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end else if (cur_seg == i2cms_pkg::SEG_ACK) begin
                    en_next = 1'b0;     // slave ACK not sampled
                end else if (cur_seg == i2cms_pkg::SEG_ACK_HIGH) begin
                    scl_next = 1'b1;
                end else begin
                    scl_next = 1'b0;
                    en_next  = 1'b1;
                end
            end
            i2cms_pkg::OP_READ: begin
                if (cur_seg < i2cms_pkg::DATA_SEGS) begin
                    if (cur_seg == 5'd0) begin
                        en_next = 1'b0;
                    end
                    case (cur_phase)
                        i2cms_pkg::PH_HIGH: begin
                            scl_next   = 1'b1;
                            shift_next = {shift_next[6:0], q_item.sda_in};
                        end
                        i2cms_pkg::PH_LOW: scl_next = 1'b0;
                        default: ;
                    endcase
                end else if (cur_seg == i2cms_pkg::SEG_ACK) begin
                    en_next  = 1'b1;
                    sda_next = !ack_next;
                end else if (cur_seg == i2cms_pkg::SEG_ACK_HIGH) begin
                    scl_next = 1'b1;
                end else begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    done     = 1'b1;
                end
            end
            default: ;
        endcase

        if (cur_op != i2cms_pkg::OP_IDLE) begin
            seg_inc = cur_seg + 5'd1;
            if (seg_inc >= i2cms_pkg::seq_len(cur_op)) begin
                op_next    = i2cms_pkg::OP_IDLE;
                seg_next   = 5'd0;
                phase_next = i2cms_pkg::PH_DATA;
            end else begin
                op_next    = cur_op;
                seg_next   = seg_inc;
                phase_next = (cur_phase == i2cms_pkg::PH_LOW) ? i2cms_pkg::PH_DATA
                                                              : cur_phase + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= i2cms_pkg::OP_IDLE;
            seg_reg     <= 5'd0;
            phase_reg   <= i2cms_pkg::PH_DATA;
            shift_reg   <= 8'd0;
            ack_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            en_reg      <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                op_reg    <= op_next;
                seg_reg   <= seg_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                ack_reg   <= ack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                en_reg    <= en_next;
            end
            if (q_ready) begin
                m_valid_reg <= q_valid;
            end
        end
    end

    // result payload; pin levels are read straight from the state registers
    always_ff @(posedge aclk) begin
        if (fire) begin
            ready_res_reg <= idle_res;
            read_done_reg <= done;
            read_byte_reg <= done ? shift_next : 8'd0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_level = scl_reg;
    assign m_sda_level = sda_reg;
    assign m_sda_drive = en_reg;
    assign m_ready_res = ready_res_reg;
    assign m_read_done = read_done_reg;
    assign m_read_byte = read_byte_reg;

    `ASSERT_IMPLIES(a_seg_range, aclk, aresetn, 1'b1, seg_reg < i2cms_pkg::LEN_BYTE)
    `ASSERT_IMPLIES(a_idle_clear, aclk, aresetn, op_reg == i2cms_pkg::OP_IDLE,
        (seg_reg == 5'd0) && (phase_reg == i2cms_pkg::PH_DATA))
    `ASSERT_IMPLIES(a_done_pins, aclk, aresetn, m_valid_reg && read_done_reg,
        !ready_res_reg && !scl_reg && sda_reg && en_reg && (op_reg == i2cms_pkg::OP_IDLE))
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid_reg && !m_ready,
        m_valid_reg && $stable(scl_reg) && $stable(seg_reg) && $stable(op_reg))

endmodule
